FILE: design/unsigned_long_divider_defines.svh
// ----------------------------------------------------------------------------
// unsigned_long_divider_defines.svh
// Assertion macros for the unsigned long divider. Properties are sampled on
// clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef UNSIGNED_LONG_DIVIDER_DEFINES_SVH
`define UNSIGNED_LONG_DIVIDER_DEFINES_SVH

`ifndef SYNTHESIS

// Plain property check.
`define ULD_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("uld: assertion failed");

// Antecedent in one cycle, consequent in the next.
`define ULD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("uld: next-cycle assertion failed");

`else

`define ULD_ASSERT(label, prop)
`define ULD_ASSERT_NEXT(label, ante, cons)

`endif

`endif

FILE: design/uld_pkg.sv
// ----------------------------------------------------------------------------
// uld_pkg
// Shared constants and controller/datapath interface types for the
// unsigned long divider.
// ----------------------------------------------------------------------------
package uld_pkg;

    localparam int WORD_BITS_DEF = 32;
    localparam int NUM_WORDS_DEF = 8;

    // Fixed port field widths.
    localparam int DATA_W = 32;
    localparam int POS_W  = 3;

    // Datapath commands, at most one of load/clear/align/step/emit per cycle.
    typedef struct packed {
        logic store;   // write the incoming word pair into the operand stores
        logic load;    // copy the run's words into the working registers
        logic clear;   // zero quotient and remainder (zero divisor)
        logic align;   // move the numerator up one word
        logic step;    // one restoring shift-compare-subtract step
        logic emit;    // drop the word just delivered
    } dp_cmd_t;

    typedef struct packed {
        logic d_zero;  // loaded divisor is zero
    } dp_stat_t;

endpackage

FILE: design/unsigned_long_divider.sv
// ----------------------------------------------------------------------------
// unsigned_long_divider
// Multi-word unsigned restoring long division. Word pairs arrive least
// significant first; the final pair starts the run, and quotient/remainder
// words are returned least significant first.
//
//   channel  handshake             payload
//   -------  --------------------  ----------------------------------------
//   in       in_valid / in_ready   numerator_word, divisor_word,
//                                  word_position, final_word
//   out      out_valid / out_ready quotient_word, remainder_word,
//                                  result_position, final_result, status
//
// A non-final pair is only stored. A final pair of a run of L words leads to
// a load, (NUM_WORDS - L) word alignments, L*WORD_BITS division steps (one
// full-width compare/subtract per cycle) and L result transactions. A zero
// divisor goes from load to results with no alignment and no steps. No
// clearing pass after reset.
// Output stalls hold the result word; input pairs keep being taken while
// results drain, up to and including the next run's final pair.
// ----------------------------------------------------------------------------
module unsigned_long_divider #(
    parameter int WORD_BITS = uld_pkg::WORD_BITS_DEF,
    parameter int NUM_WORDS = uld_pkg::NUM_WORDS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [uld_pkg::DATA_W-1:0]  numerator_word,
    input  logic [uld_pkg::DATA_W-1:0]  divisor_word,
    input  logic [uld_pkg::POS_W-1:0]   word_position,
    input  logic                        final_word,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [uld_pkg::DATA_W-1:0]  quotient_word,
    output logic [uld_pkg::DATA_W-1:0]  remainder_word,
    output logic [uld_pkg::POS_W-1:0]   result_position,
    output logic                        final_result,
    output logic                        status
);

    localparam int LEN_W = $clog2(NUM_WORDS + 1);

    uld_pkg::dp_cmd_t  cmd;
    uld_pkg::dp_stat_t stat;
    logic [LEN_W-1:0]  len;

    uld_ctrl #(
        .WORD_BITS (WORD_BITS),
        .NUM_WORDS (NUM_WORDS)
    ) u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .word_position   (word_position),
        .final_word      (final_word),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .result_position (result_position),
        .final_result    (final_result),
        .stat            (stat),
        .cmd             (cmd),
        .len             (len)
    );

    uld_datapath #(
        .WORD_BITS (WORD_BITS),
        .NUM_WORDS (NUM_WORDS)
    ) u_datapath (
        .clk            (clk),
        .cmd            (cmd),
        .len            (len),
        .numerator_word (numerator_word),
        .divisor_word   (divisor_word),
        .word_position  (word_position),
        .stat           (stat),
        .quotient_word  (quotient_word),
        .remainder_word (remainder_word)
    );

    assign status = stat.d_zero;

endmodule

FILE: design/uld_datapath.sv
// ----------------------------------------------------------------------------
// uld_datapath
// Operand stores and the full-width remainder/quotient/divisor registers.
// One restoring division step per cycle over the full register width.
// ----------------------------------------------------------------------------
module uld_datapath #(
    parameter int WORD_BITS = uld_pkg::WORD_BITS_DEF,
    parameter int NUM_WORDS = uld_pkg::NUM_WORDS_DEF
) (
    input  logic                            clk,
    input  uld_pkg::dp_cmd_t                cmd,
    input  logic [$clog2(NUM_WORDS+1)-1:0]  len,
    input  logic [uld_pkg::DATA_W-1:0]      numerator_word,
    input  logic [uld_pkg::DATA_W-1:0]      divisor_word,
    input  logic [uld_pkg::POS_W-1:0]       word_position,
    output uld_pkg::dp_stat_t               stat,
    output logic [uld_pkg::DATA_W-1:0]      quotient_word,
    output logic [uld_pkg::DATA_W-1:0]      remainder_word
);

    localparam int TW    = NUM_WORDS * WORD_BITS;
    localparam int LEN_W = $clog2(NUM_WORDS + 1);
    localparam int MW    = (NUM_WORDS > 8) ? $clog2(NUM_WORDS) : uld_pkg::POS_W;

    logic [WORD_BITS-1:0] num_store [NUM_WORDS];
    logic [WORD_BITS-1:0] div_store [NUM_WORDS];

    logic [TW-1:0] q_reg, q_next;
    logic [TW-1:0] a_reg, a_next;
    logic [TW-1:0] d_reg, d_next;

    logic [TW-1:0] q_load, d_load;
    logic [TW:0]   a_sh;
    logic [TW+1:0] diff;
    logic          borrow;

    // Operand stores: positions past the store are dropped
    for (genvar i = 0; i < NUM_WORDS; i++) begin : g_store
        always_ff @(posedge clk)
        begin
            if (cmd.store && (MW'(word_position) == MW'(i)))
            begin
                num_store[i] <= WORD_BITS'(numerator_word);
                div_store[i] <= WORD_BITS'(divisor_word);
            end
        end

        // Words beyond the run length count as zero
        assign q_load[i*WORD_BITS +: WORD_BITS] =
            (LEN_W'(i) < len) ? num_store[i] : '0;
        assign d_load[i*WORD_BITS +: WORD_BITS] =
            (LEN_W'(i) < len) ? div_store[i] : '0;
    end

    assign a_sh   = {a_reg, q_reg[TW-1]};
    assign diff   = {1'b0, a_sh} - {2'b00, d_reg};
    assign borrow = diff[TW+1];

    always_comb
    begin
        q_next = q_reg;
        a_next = a_reg;
        d_next = d_reg;
        if (cmd.load)
        begin
            q_next = q_load;
            a_next = '0;
            d_next = d_load;
        end
        else if (cmd.clear)
        begin
            q_next = '0;
            a_next = '0;
        end
        else if (cmd.align)
        begin
            q_next = q_reg << WORD_BITS;
        end
        else if (cmd.step)
        begin
            q_next = {q_reg[TW-2:0], ~borrow};
            // a_sh < 2*d, so a kept shift fits back in TW bits
            a_next = borrow ? a_sh[TW-1:0] : diff[TW-1:0];
        end
        else if (cmd.emit)
        begin
            q_next = q_reg >> WORD_BITS;
            a_next = a_reg >> WORD_BITS;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        a_reg <= a_next;
        d_reg <= d_next;
    end

    assign stat.d_zero    = (d_reg == '0);
    assign quotient_word  = uld_pkg::DATA_W'(q_reg[WORD_BITS-1:0]);
    assign remainder_word = uld_pkg::DATA_W'(a_reg[WORD_BITS-1:0]);

endmodule

FILE: design/uld_ctrl.sv
// ----------------------------------------------------------------------------
// uld_ctrl
// Sequencer for the unsigned long divider: operand intake, load, word
// alignment, division steps and result delivery.
// ----------------------------------------------------------------------------
`include "unsigned_long_divider_defines.svh"

module uld_ctrl #(
    parameter int WORD_BITS = uld_pkg::WORD_BITS_DEF,
    parameter int NUM_WORDS = uld_pkg::NUM_WORDS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [uld_pkg::POS_W-1:0]       word_position,
    input  logic                            final_word,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [uld_pkg::POS_W-1:0]       result_position,
    output logic                            final_result,
    input  uld_pkg::dp_stat_t               stat,
    output uld_pkg::dp_cmd_t                cmd,
    output logic [$clog2(NUM_WORDS+1)-1:0]  len
);

    localparam int TW    = NUM_WORDS * WORD_BITS;
    localparam int LEN_W = $clog2(NUM_WORDS + 1);
    localparam int PW    = (LEN_W > 4) ? LEN_W : 4;
    localparam int CNT_W = $clog2(TW + 1);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_LOAD  = 5'b00010,
        S_ALIGN = 5'b00100,
        S_DIV   = 5'b01000,
        S_EMIT  = 5'b10000
    } state_t;

    state_t                    state_reg, state_next;
    logic [LEN_W-1:0]          len_reg, len_next;
    logic [LEN_W-1:0]          left_reg, left_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic [uld_pkg::POS_W-1:0] pos_reg, pos_next;
    logic                      pending_reg, pending_next;

    logic [PW-1:0]    pos_plus;
    logic [LEN_W-1:0] len_in;
    logic             in_acc, out_acc, start_req;

    // Run length: position + 1, saturated at the store depth
    assign pos_plus = PW'(word_position) + PW'(1);
    assign len_in   = (pos_plus > PW'(NUM_WORDS)) ? LEN_W'(NUM_WORDS) : LEN_W'(pos_plus);

    assign in_ready  = (state_reg == S_IDLE) || ((state_reg == S_EMIT) && !pending_reg);
    assign out_valid = (state_reg == S_EMIT);
    assign in_acc    = in_valid && in_ready;
    assign out_acc   = out_valid && out_ready;
    assign start_req = in_acc && final_word;

    always_comb
    begin
        state_next   = state_reg;
        len_next     = len_reg;
        left_next    = left_reg;
        cnt_next     = cnt_reg;
        pos_next     = pos_reg;
        pending_next = pending_reg;
        cmd          = '0;
        cmd.store    = in_acc;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start_req)
                begin
                    len_next   = len_in;
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                cmd.load   = 1'b1;
                cnt_next   = CNT_W'(NUM_WORDS) - CNT_W'(len_reg);
                state_next = S_ALIGN;
            end
            S_ALIGN:
            begin
                if (stat.d_zero)
                begin
                    cmd.clear  = 1'b1;
                    left_next  = len_reg;
                    pos_next   = '0;
                    state_next = S_EMIT;
                end
                else if (cnt_reg == '0)
                begin
                    cnt_next   = CNT_W'(len_reg) * CNT_W'(WORD_BITS);
                    state_next = S_DIV;
                end
                else
                begin
                    cmd.align = 1'b1;
                    cnt_next  = cnt_reg - CNT_W'(1);
                end
            end
            S_DIV:
            begin
                cmd.step = 1'b1;
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    left_next  = len_reg;
                    pos_next   = '0;
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                // Next run's final pair may arrive while results drain
                if (start_req)
                begin
                    len_next     = len_in;
                    pending_next = 1'b1;
                end
                if (out_acc)
                begin
                    cmd.emit  = 1'b1;
                    left_next = left_reg - LEN_W'(1);
                    pos_next  = pos_reg + uld_pkg::POS_W'(1);
                    if (left_reg == LEN_W'(1))
                    begin
                        if (pending_next)
                        begin
                            pending_next = 1'b0;
                            state_next   = S_LOAD;
                        end
                        else
                        begin
                            state_next = S_IDLE;
                        end
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            pending_reg <= 1'b0;
            left_reg    <= '0;
            cnt_reg     <= '0;
            len_reg     <= '0;
            pos_reg     <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            pending_reg <= pending_next;
            left_reg    <= left_next;
            cnt_reg     <= cnt_next;
            len_reg     <= len_next;
            pos_reg     <= pos_next;
        end
    end

    assign len             = len_reg;
    assign result_position = pos_reg;
    assign final_result    = (left_reg == LEN_W'(1));

    `ULD_ASSERT(a_emit_has_words, (state_reg == S_EMIT) |-> (left_reg != '0))
    `ULD_ASSERT(a_div_has_steps, (state_reg == S_DIV) |-> (cnt_reg != '0))
    `ULD_ASSERT(a_pending_blocks_input, pending_reg |-> !in_ready)
    `ULD_ASSERT_NEXT(a_last_word_ends_emit, out_valid && out_ready && final_result, state_reg != S_EMIT)

endmodule

FILE: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the unsigned long divider. Word pairs go in through
// the input handshake. Each final pair is predicted with full-width integer
// division over the run's words, and every result transaction is compared
// field by field against the oldest prediction. Directed cases come first,
// then random runs, noise and stale-word runs. Random stalls are applied on
// both channels, except in the last part of the run.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WORDS          = uld_pkg::NUM_WORDS_DEF;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 300;
    localparam int RANDOM_ITEMS   = 320;
    localparam int STEADY_ITEMS   = 60;

    localparam logic STATUS_OK       = 1'b0;
    localparam logic STATUS_DIV_ZERO = 1'b1;

    typedef logic [uld_pkg::DATA_W-1:0]       word_t;
    typedef logic [uld_pkg::POS_W-1:0]        pos_t;
    typedef logic [WORDS*uld_pkg::DATA_W-1:0] wide_t;

    typedef struct packed {
        word_t quotient;
        word_t remainder;
        pos_t  position;
        logic  is_last;
        logic  status;
    } result_word_t;

    logic  clk;
    logic  rst_n;
    logic  in_valid;
    logic  in_ready;
    word_t numerator_word;
    word_t divisor_word;
    pos_t  word_position;
    logic  final_word;
    logic  out_valid;
    logic  out_ready;
    word_t quotient_word;
    word_t remainder_word;
    pos_t  result_position;
    logic  final_result;
    logic  status;

    // Operand words as the block holds them, and the results still owed
    word_t        numer_mem [WORDS];
    word_t        denom_mem [WORDS];
    result_word_t owed_results[$];

    bit idle_on;
    int mismatches;
    int pairs_sent;
    int runs_sent;
    int zero_div_runs;
    int words_checked;
    int quiet_cycles;
    int ready_hold;

    unsigned_long_divider i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .numerator_word  (numerator_word),
        .divisor_word    (divisor_word),
        .word_position   (word_position),
        .final_word      (final_word),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .quotient_word   (quotient_word),
        .remainder_word  (remainder_word),
        .result_position (result_position),
        .final_result    (final_result),
        .status          (status)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    task automatic report_mismatch(input string what, input word_t got, input word_t want);
        $display("MISMATCH %s: got %h, expected %h at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    // Quotient and remainder of the first len stored words, one entry per word
    function automatic void divide_run(input int len);
        wide_t        numer;
        wide_t        denom;
        wide_t        quot;
        wide_t        rem;
        logic         st;
        result_word_t r;
        numer = '0;
        denom = '0;
        for (int i = 0; i < len; i++)
        begin
            numer[i*uld_pkg::DATA_W +: uld_pkg::DATA_W] = numer_mem[i];
            denom[i*uld_pkg::DATA_W +: uld_pkg::DATA_W] = denom_mem[i];
        end
        if (denom == '0)
        begin
            quot = '0;
            rem  = '0;
            st   = STATUS_DIV_ZERO;
            zero_div_runs++;
        end
        else
        begin
            quot = numer / denom;
            rem  = numer % denom;
            st   = STATUS_OK;
        end
        for (int k = 0; k < len; k++)
        begin
            r.quotient  = quot[k*uld_pkg::DATA_W +: uld_pkg::DATA_W];
            r.remainder = rem[k*uld_pkg::DATA_W +: uld_pkg::DATA_W];
            r.position  = pos_t'(k);
            r.is_last   = (k == len - 1);
            r.status    = st;
            owed_results.push_back(r);
        end
    endfunction

    // One word-pair transaction; records the pair on acceptance, predicts on a final pair
    task automatic send_pair(input word_t num, input word_t den, input pos_t pos,
                             input logic fin);
        int gap;
        int len;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 5);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid       <= 1'b1;
        numerator_word <= num;
        divisor_word   <= den;
        word_position  <= pos;
        final_word     <= fin;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (int'(pos) < WORDS)
        begin
            numer_mem[pos] = num;
            denom_mem[pos] = den;
        end
        pairs_sent++;
        if (fin)
        begin
            len = int'(pos) + 1;
            if (len > WORDS)
                len = WORDS;
            divide_run(len);
            runs_sent++;
        end
    endtask

    function automatic word_t pick_word();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return word_t'($urandom_range(1, 255));
            3:       return word_t'(1) << $urandom_range(0, uld_pkg::DATA_W - 1);
            default: return word_t'($urandom);
        endcase
    endfunction

    // Well-formed run: positions 0..len-1 in order, final on the last.
    // Divisor height is random so the number of nonzero divisor words varies.
    task automatic send_run(input int len);
        int    height;
        bit    zero_den;
        word_t den;
        height   = $urandom_range(1, len);
        zero_den = ($urandom_range(0, 11) == 0);
        for (int p = 0; p < len; p++)
        begin
            den = (zero_den || p >= height) ? word_t'(0) : pick_word();
            send_pair(pick_word(), den, pos_t'(p), p == len - 1);
        end
    endtask

    // Writes every store word, so no later run reads an unwritten entry.
    // All-ones over one gives the widest quotient, with no word alignment.
    task automatic test_full_width_run();
        for (int p = 0; p < WORDS; p++)
            send_pair('1, (p == 0) ? word_t'(1) : word_t'(0), pos_t'(p), p == WORDS - 1);
    endtask

    task automatic test_extremes();
        send_pair('0, '1, pos_t'(0), 1'b1);
        send_pair('1, '1, pos_t'(0), 1'b1);
        send_pair('1, word_t'(1), pos_t'(0), 1'b1);
        send_pair(32'h8000_0000, 32'h0000_0003, pos_t'(0), 1'b1);
    endtask

    task automatic test_zero_divisor();
        send_pair(32'h1234_5678, '0, pos_t'(0), 1'b0);
        send_pair('1, '0, pos_t'(1), 1'b1);
    endtask

    task automatic test_small_numerator();
        send_pair(32'h0000_0005, 32'h0000_0007, pos_t'(0), 1'b0);
        send_pair('0, 32'h0000_0001, pos_t'(1), 1'b1);
    endtask

    // Lower words left from earlier runs; a lone non-final pair stores only
    task automatic test_stale_words();
        send_pair(32'hdead_beef, 32'h0000_0100, pos_t'(5), 1'b0);
        send_pair(32'hcafe_f00d, 32'h0000_0011, pos_t'(3), 1'b1);
        send_pair(32'h0000_0001, 32'hffff_0000, pos_t'(7), 1'b1);
    endtask

    task automatic test_random_traffic(input int count);
        int target;
        int len;
        int n;
        target = pairs_sent + count;
        while (pairs_sent < target)
        begin
            idle_on = ($urandom_range(0, 5) != 0);
            if ($urandom_range(0, 4) != 0)
            begin
                len = ($urandom_range(0, 11) == 0) ? WORDS : $urandom_range(1, 4);
                send_run(len);
            end
            else
            begin
                // noise: out-of-order positions, stray finals over stale words
                n = $urandom_range(1, 3);
                repeat (n)
                    send_pair(pick_word(), pick_word(), pos_t'($urandom_range(0, WORDS - 1)),
                              $urandom_range(0, 2) == 0);
            end
        end
    endtask

    task automatic test_steady_stream(input int count);
        int target;
        target  = pairs_sent + count;
        idle_on = 1'b0;
        while (pairs_sent < target)
            send_run($urandom_range(1, 3));
    endtask

    always @(posedge clk)
    begin : ready_driver
        if (!idle_on)
            out_ready <= 1'b1;
        else if (ready_hold > 0)
        begin
            ready_hold = ready_hold - 1;
            out_ready <= 1'b0;
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            ready_hold = $urandom_range(0, 4);
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    always @(posedge clk)
    begin : result_checker
        result_word_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (owed_results.size() == 0)
                report_mismatch("result with nothing owed (quotient)", quotient_word, '0);
            else
            begin
                want = owed_results.pop_front();
                words_checked++;
                if (quotient_word !== want.quotient)
                    report_mismatch("quotient_word", quotient_word, want.quotient);
                if (remainder_word !== want.remainder)
                    report_mismatch("remainder_word", remainder_word, want.remainder);
                if (result_position !== want.position)
                    report_mismatch("result_position", word_t'(result_position),
                                    word_t'(want.position));
                if (final_result !== want.is_last)
                    report_mismatch("final_result", word_t'(final_result),
                                    word_t'(want.is_last));
                if (status !== want.status)
                    report_mismatch("status", word_t'(status), word_t'(want.status));
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles <= 0;
            else if (quiet_cycles + 1 >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no transaction for %0d cycles, %0d words owed",
                         WATCHDOG_LIMIT, owed_results.size());
                $display("FAILED: results differ");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        numerator_word = '0;
        divisor_word   = '0;
        word_position  = '0;
        final_word     = 1'b0;
        out_ready      = 1'b0;
        idle_on        = 1'b1;
        ready_hold     = 0;
        quiet_cycles   = 0;
        mismatches     = 0;
        pairs_sent     = 0;
        runs_sent      = 0;
        zero_div_runs  = 0;
        words_checked  = 0;
        for (int i = 0; i < WORDS; i++)
        begin
            numer_mem[i] = '0;
            denom_mem[i] = '0;
        end
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_full_width_run();
        test_extremes();
        test_zero_divisor();
        test_small_numerator();
        test_stale_words();
        test_random_traffic(RANDOM_ITEMS);
        test_steady_stream(STEADY_ITEMS);
        in_valid <= 1'b0;

        while (owed_results.size() != 0)
            @(posedge clk);
        // catch any stray result words after the last one owed
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d word pairs forming %0d division runs (%0d with zero divisor)",
                 pairs_sent, runs_sent, zero_div_runs);
        $display("Checked %0d result words, %0d mismatches", words_checked, mismatches);
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

FILE: unsigned_long_divider.f
+incdir+design
design/uld_pkg.sv
design/uld_datapath.sv
design/uld_ctrl.sv
design/unsigned_long_divider.sv
sim/tb_top.sv
